FILE: rtl/core/bsoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsoc_pkg - shared types and constants of the barometer compensation core
// Calibration word bundle, stage payload records and register indexes.
// ============================================================================
package bsoc_pkg;

   localparam int unsigned INDEX_W = 3;

   localparam logic [INDEX_W-1:0] CSR_PRESSURE_SENSITIVITY   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_PRESSURE_OFFSET        = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_SENSITIVITY_TEMP_COEFF = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_OFFSET_TEMP_COEFF      = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_REFERENCE_TEMPERATURE  = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_TEMPERATURE_SLOPE      = 3'd5;

   // 20.00 degC in 0.01 degC, and -15.00 degC expressed relative to 20.00 degC.
   localparam logic signed [18:0] TEMP_BASE     = 19'sd2000;
   localparam logic signed [18:0] VERY_COLD_LO  = -19'sd3500;
   localparam logic signed [18:0] VERY_COLD_OFS = 19'sd3500;

   typedef struct packed {
      logic [15:0] pressure_sensitivity;
      logic [15:0] pressure_offset;
      logic [15:0] sensitivity_temp_coeff;
      logic [15:0] offset_temp_coeff;
      logic [15:0] reference_temperature;
      logic [15:0] temperature_slope;
   } cal_type;

   // First-order results leaving the front pipeline.
   typedef struct packed {
      logic [23:0]        raw_pressure;
      logic signed [17:0] temp_delta;     // TEMP - 2000
      logic [16:0]        t2;
      logic signed [35:0] off;
      logic signed [34:0] sens;
   } first_type;

   // Corrected terms leaving the second-order pipeline.
   typedef struct packed {
      logic [23:0]        raw_pressure;
      logic signed [18:0] temperature;
      logic signed [39:0] off;
      logic signed [39:0] sens;
   } corr_type;

endpackage
`default_nettype wire

FILE: rtl/core/bsoc_csr_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsoc_csr_regs - calibration word registers
// Holds the six factory calibration words; writes to unused indexes are dropped.
// ============================================================================
module bsoc_csr_regs
   import bsoc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [INDEX_W-1:0] csr_index,
   input  wire logic [15:0]        csr_data,
   output cal_type                 cal
);

   cal_type cal_ff;
   cal_type cal_in;

   assign csr_ready = 1'b1;
   assign cal       = cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESSURE_SENSITIVITY:   cal_in.pressure_sensitivity   = csr_data;
            CSR_PRESSURE_OFFSET:        cal_in.pressure_offset        = csr_data;
            CSR_SENSITIVITY_TEMP_COEFF: cal_in.sensitivity_temp_coeff = csr_data;
            CSR_OFFSET_TEMP_COEFF:      cal_in.offset_temp_coeff      = csr_data;
            CSR_REFERENCE_TEMPERATURE:  cal_in.reference_temperature  = csr_data;
            CSR_TEMPERATURE_SLOPE:      cal_in.temperature_slope      = csr_data;
            default:                    cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

`ifndef SYNTHESIS
   a_unused_index_ignored: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index > CSR_TEMPERATURE_SLOPE) |=> $stable(cal_ff))
      else $error("write to an unused index changed a calibration word");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/bsoc_first_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsoc_first_order - dT, first-order TEMP, OFF and SENS
// Three stages: dT, the four products of dT, then shifts and offsets.
// ============================================================================
module bsoc_first_order
   import bsoc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cal_type     cal,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [23:0] raw_pressure,
   input  wire logic [23:0] raw_temperature,
   output logic             out_valid,
   input  wire logic        out_ready,
   output first_type        out_data
);

   logic [2:0] v_ff;
   logic [2:0] adv;

   // Stage 1
   logic [23:0]        d1_s1_ff;
   logic signed [24:0] dt_in, dt_ff;
   // Stage 2
   logic [23:0]        d1_s2_ff;
   logic signed [41:0] p_temp_in, p_temp_ff;
   logic signed [41:0] p_off_in, p_off_ff;
   logic signed [41:0] p_sens_in, p_sens_ff;
   logic signed [49:0] dd_full;
   logic [47:0]        dd_in, dd_ff;
   // Stage 3
   first_type          res_in, res_ff;

   always_comb begin
      adv[2] = !v_ff[2] || out_ready;
      adv[1] = !v_ff[1] || adv[2];
      adv[0] = !v_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[2];
   assign out_data  = res_ff;

   always_comb begin
      dt_in = $signed({1'b0, raw_temperature})
            - $signed({1'b0, cal.reference_temperature, 8'h00});
   end

   always_comb begin
      p_temp_in = dt_ff * $signed({1'b0, cal.temperature_slope});
      p_off_in  = dt_ff * $signed({1'b0, cal.offset_temp_coeff});
      p_sens_in = dt_ff * $signed({1'b0, cal.sensitivity_temp_coeff});
      dd_full   = dt_ff * dt_ff;
      dd_in     = dd_full[47:0];
   end

   // Arithmetic right shifts are taken as sign-kept part-selects.
   always_comb begin
      res_in.raw_pressure = d1_s2_ff;
      res_in.temp_delta   = p_temp_ff[40:23];
      res_in.t2           = dd_ff[47:31];
      res_in.off          = $signed({4'b0, cal.pressure_offset, 16'h0000})
                          + $signed({p_off_ff[41], p_off_ff[41:7]});
      res_in.sens         = $signed({4'b0, cal.pressure_sensitivity, 15'h0000})
                          + $signed({p_sens_ff[41], p_sens_ff[41:8]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d1_s1_ff <= raw_pressure;
         dt_ff    <= dt_in;
      end
      if (adv[1]) begin
         d1_s2_ff  <= d1_s1_ff;
         p_temp_ff <= p_temp_in;
         p_off_ff  <= p_off_in;
         p_sens_ff <= p_sens_in;
         dd_ff     <= dd_in;
      end
      if (adv[2]) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/bsoc_second_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsoc_second_order - low-temperature corrections T2, OFF2 and SENS2
// Two stages: the squares and final temperature, then the corrected terms.
// ============================================================================
module bsoc_second_order
   import bsoc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire first_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output corr_type       out_data
);

   logic [1:0] v_ff;
   logic [1:0] adv;

   // Stage 4
   logic               cold_in, cold_ff;
   logic               very_cold_in, very_cold_ff;
   logic signed [18:0] vlo;
   logic signed [35:0] sq_full;
   logic signed [37:0] vsq_full;
   logic [34:0]        sq_in, sq_ff;
   logic [34:0]        vsq_in, vsq_ff;
   logic signed [18:0] temperature_in, temperature_ff;
   logic [23:0]        d1_ff;
   logic signed [35:0] off_ff;
   logic signed [34:0] sens_ff;
   // Stage 5
   logic [37:0]        five_sq;
   logic [37:0]        seven_vsq;
   logic [37:0]        eleven_vsq;
   logic [39:0]        off2;
   logic [39:0]        sens2;
   corr_type           res_in, res_ff;

   always_comb begin
      adv[1] = !v_ff[1] || out_ready;
      adv[0] = !v_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[1];
   assign out_data  = res_ff;

   always_comb begin
      cold_in      = in_data.temp_delta[17];
      very_cold_in = $signed({in_data.temp_delta[17], in_data.temp_delta}) < VERY_COLD_LO;
      vlo          = $signed({in_data.temp_delta[17], in_data.temp_delta}) + VERY_COLD_OFS;
      sq_full      = in_data.temp_delta * in_data.temp_delta;
      vsq_full     = vlo * vlo;
      sq_in        = sq_full[34:0];
      vsq_in       = vsq_full[34:0];
      temperature_in = TEMP_BASE + $signed({in_data.temp_delta[17], in_data.temp_delta})
                     - $signed(cold_in ? {2'b00, in_data.t2} : 19'd0);
   end

   // The corrections are non-negative, so their shifts are plain.
   always_comb begin
      five_sq    = {3'b000, sq_ff} + {1'b0, sq_ff, 2'b00};
      seven_vsq  = {vsq_ff, 3'b000} - {3'b000, vsq_ff};
      eleven_vsq = {vsq_ff, 3'b000} + {2'b00, vsq_ff, 1'b0} + {3'b000, vsq_ff};
      off2  = '0;
      sens2 = '0;
      if (cold_ff) begin
         off2  = {3'b000, five_sq[37:1]};
         sens2 = {4'b0000, five_sq[37:2]};
         if (very_cold_ff) begin
            off2  = off2 + {2'b00, seven_vsq};
            sens2 = sens2 + {3'b000, eleven_vsq[37:1]};
         end
      end
      res_in.raw_pressure = d1_ff;
      res_in.temperature  = temperature_ff;
      res_in.off  = $signed({{4{off_ff[35]}}, off_ff}) - $signed(off2);
      res_in.sens = $signed({{5{sens_ff[34]}}, sens_ff}) - $signed(sens2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cold_ff        <= cold_in;
         very_cold_ff   <= very_cold_in;
         sq_ff          <= sq_in;
         vsq_ff         <= vsq_in;
         temperature_ff <= temperature_in;
         d1_ff          <= in_data.raw_pressure;
         off_ff         <= in_data.off;
         sens_ff        <= in_data.sens;
      end
      if (adv[1]) begin
         res_ff <= res_in;
      end
   end

`ifndef SYNTHESIS
   a_warm_not_lowered: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && !cold_ff |-> temperature_ff >= TEMP_BASE)
      else $error("temperature at or above 20 degC was given a correction");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/bsoc_pressure.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsoc_pressure - compensated pressure from D1, SENS and OFF
// Three stages: split D1*SENS partial products, their sum, the final offset.
// ============================================================================
module bsoc_pressure
   import bsoc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire corr_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output logic [18:0]   temperature_centideg,
   output logic [26:0]   pressure_centimbar
);

   logic [2:0] v_ff;
   logic [2:0] adv;

   // Stage 6: SENS is cut into a signed upper and an unsigned lower half.
   logic [43:0]        pl_in, pl_ff;
   logic signed [44:0] ph_in, ph_ff;
   logic signed [39:0] off_s6_ff;
   logic signed [18:0] temp_s6_ff;
   // Stage 7
   logic [63:0]        full;
   logic signed [42:0] scaled_in, scaled_ff;
   logic signed [39:0] off_s7_ff;
   logic signed [18:0] temp_s7_ff;
   // Stage 8
   logic signed [43:0] diff;
   logic [26:0]        press_in, press_ff;
   logic [18:0]        temp_out_ff;

   always_comb begin
      adv[2] = !v_ff[2] || out_ready;
      adv[1] = !v_ff[1] || adv[2];
      adv[0] = !v_ff[0] || adv[1];
   end

   assign in_ready             = adv[0];
   assign out_valid            = v_ff[2];
   assign temperature_centideg = temp_out_ff;
   assign pressure_centimbar   = press_ff;

   always_comb begin
      pl_in = {20'h00000, in_data.raw_pressure} * {24'h000000, in_data.sens[19:0]};
      ph_in = $signed({1'b0, in_data.raw_pressure}) * $signed(in_data.sens[39:20]);
   end

   always_comb begin
      full      = {ph_ff[43:0], 20'h00000} + {20'h00000, pl_ff};
      scaled_in = full[63:21];
   end

   always_comb begin
      diff     = $signed({scaled_ff[42], scaled_ff}) - $signed({{4{off_s7_ff[39]}}, off_s7_ff});
      press_in = diff[41:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pl_ff      <= pl_in;
         ph_ff      <= ph_in;
         off_s6_ff  <= in_data.off;
         temp_s6_ff <= in_data.temperature;
      end
      if (adv[1]) begin
         scaled_ff  <= scaled_in;
         off_s7_ff  <= off_s6_ff;
         temp_s7_ff <= temp_s6_ff;
      end
      if (adv[2]) begin
         press_ff    <= press_in;
         temp_out_ff <= temp_s7_ff;
      end
   end

`ifndef SYNTHESIS
   a_full_and_stalled_blocks: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !out_ready |-> !in_ready)
      else $error("pressure pipeline took a transfer while full and stalled");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v_ff[0])
      else $error("accepted transfer was lost at the first pressure stage");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/barometer_second_order_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// barometer_second_order_compensation_core - barometer compensation top level
// Turns raw pressure and temperature conversions into 0.01 degC and 0.01 mbar.
// ============================================================================
// Each transfer on the req_ channel carries one raw pressure and one raw
// temperature conversion; the rsp_ channel returns one compensated
// temperature and pressure for it, in order. The datapath is an eight-stage
// pipeline (three stages for dT and the first-order terms, two for the
// low-temperature corrections, three for the split D1*SENS product and the
// final offset), and one request can be taken every cycle while rsp_tready
// keeps taking results. Every stage holds its own valid bit and only stalls
// when it is occupied and the stage after it cannot take its contents, so
// gaps in the pipeline are taken up while rsp_tready is low. Calibration
// words are written on the csr_ channel, which is always ready, and should
// only be changed while no request is in flight.
module barometer_second_order_compensation_core
   import bsoc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // Calibration word write channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [INDEX_W-1:0] csr_index,
   input  wire logic [15:0]        csr_data,
   // Request stream
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [47:0]        req_tdata,  // [23:0] raw_pressure, [47:24] raw_temperature
   // Response stream
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [47:0]             rsp_tdata   // [18:0] temperature_centideg,
                                               // [45:19] pressure_centimbar, [47:46] zero
);

   cal_type     cal;
   logic        first_valid, first_ready;
   first_type   first_data;
   logic        corr_valid, corr_ready;
   corr_type    corr_data;
   logic [18:0] temperature_centideg;
   logic [26:0] pressure_centimbar;

   bsoc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cal       (cal)
   );

   bsoc_first_order u_first (
      .clock           (clock),
      .reset           (reset),
      .cal             (cal),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .raw_pressure    (req_tdata[23:0]),
      .raw_temperature (req_tdata[47:24]),
      .out_valid       (first_valid),
      .out_ready       (first_ready),
      .out_data        (first_data)
   );

   bsoc_second_order u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_ready  (first_ready),
      .in_data   (first_data),
      .out_valid (corr_valid),
      .out_ready (corr_ready),
      .out_data  (corr_data)
   );

   bsoc_pressure u_press (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (corr_valid),
      .in_ready             (corr_ready),
      .in_data              (corr_data),
      .out_valid            (rsp_tvalid),
      .out_ready            (rsp_tready),
      .temperature_centideg (temperature_centideg),
      .pressure_centimbar   (pressure_centimbar)
   );

   assign rsp_tdata = {2'b00, pressure_centimbar, temperature_centideg};

endmodule
`default_nettype wire

FILE: dv/barometer_second_order_compensation_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// barometer_second_order_compensation_core_tb - self-checking testbench
// Drives raw pressure and temperature pairs through the compensation core
// under several calibration sets and varying back-pressure. Each response is
// compared field by field with a bit-exact prediction made at request time.
// ============================================================================
module barometer_second_order_compensation_core_tb
   import bsoc_pkg::*;
;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int RESET_CYCLES     = 7;
   localparam int PIPE_SETTLE      = 16;
   localparam int RX_STALL_CYCLES  = 400;
   localparam int RANDOM_PER_PHASE = 135;

   // Temperature thresholds of the second-order correction, in 0.01 degC.
   localparam longint TEMP_REF_CENTI  = 2000;
   localparam longint VERY_COLD_CENTI = -1500;

   // Indexes beyond the calibration bank; writes to them must be ignored.
   localparam logic [INDEX_W-1:0] CSR_UNUSED_SIX   = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_UNUSED_SEVEN = 3'd7;

   typedef struct {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } sample_pair_type;

   typedef struct {
      logic signed [18:0] temperature_centideg;
      logic signed [26:0] pressure_centimbar;
   } comp_result_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [47:0]        req_tdata = '0;   // [23:0] raw_pressure, [47:24] raw_temperature
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [47:0]        rsp_tdata;        // [18:0] temperature_centideg,
                                         // [45:19] pressure_centimbar

   cal_type           cal_shadow = '0;
   sample_pair_type   sample_queue[$];
   comp_result_type   compensated_queue[$];
   sample_pair_type   req_pair;
   comp_result_type   rsp_want;
   int unsigned       items_issued = 0;
   int unsigned       results_seen = 0;
   int unsigned       failures = 0;
   int unsigned       cycle_count = 0;
   int unsigned       tx_idle_pct = 0;
   int unsigned       rx_idle_pct = 0;
   bit                rx_stall_req = 1'b0;
   bit                rx_stall_done = 1'b0;
   int unsigned       rx_stall_left = 0;

   barometer_second_order_compensation_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact 64-bit compensation; >>> on a signed longint floors, as required.
   function automatic comp_result_type compensate(sample_pair_type s);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, lo_sq, vc_sq, press;
      comp_result_type r;
      d1 = longint'(s.raw_pressure);
      d2 = longint'(s.raw_temperature);
      c1 = longint'(cal_shadow.pressure_sensitivity);
      c2 = longint'(cal_shadow.pressure_offset);
      c3 = longint'(cal_shadow.sensitivity_temp_coeff);
      c4 = longint'(cal_shadow.offset_temp_coeff);
      c5 = longint'(cal_shadow.reference_temperature);
      c6 = longint'(cal_shadow.temperature_slope);
      dt    = d2 - c5 * 256;
      temp  = TEMP_REF_CENTI + ((dt * c6) >>> 23);
      off   = c2 * 65536 + ((c4 * dt) >>> 7);
      sens  = c1 * 32768 + ((c3 * dt) >>> 8);
      t2    = 0;
      off2  = 0;
      sens2 = 0;
      if (temp < TEMP_REF_CENTI) begin
         lo_sq = (temp - TEMP_REF_CENTI) * (temp - TEMP_REF_CENTI);
         t2    = (dt * dt) >>> 31;
         off2  = (5 * lo_sq) >>> 1;
         sens2 = (5 * lo_sq) >>> 2;
         if (temp < VERY_COLD_CENTI) begin
            vc_sq = (temp - VERY_COLD_CENTI) * (temp - VERY_COLD_CENTI);
            off2  = off2 + 7 * vc_sq;
            sens2 = sens2 + ((11 * vc_sq) >>> 1);
         end
      end
      temp  = temp - t2;
      off   = off - off2;
      sens  = sens - sens2;
      press = (((d1 * sens) >>> 21) - off) >>> 15;
      r.temperature_centideg = temp[18:0];
      r.pressure_centimbar   = press[26:0];
      return r;
   endfunction

   // Request driver: the prediction is made at the edge where the transfer happens.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            compensated_queue.push_back(compensate(req_pair));
         end
         if (sample_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            req_pair = sample_queue.pop_front();
            req_tdata <= {req_pair.raw_temperature, req_pair.raw_pressure};
            req_tvalid <= 1'b1;
            items_issued++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor and back-pressure, including one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (compensated_queue.size() == 0) begin
               failures++;
               $display("%0t: unexpected response, got tdata %h", $time, rsp_tdata);
            end else begin
               rsp_want = compensated_queue.pop_front();
               if ($signed(rsp_tdata[18:0]) !== rsp_want.temperature_centideg) begin
                  failures++;
                  $display("%0t: temperature_centideg mismatch, expected %0d, got %0d",
                           $time, rsp_want.temperature_centideg, $signed(rsp_tdata[18:0]));
               end
               if ($signed(rsp_tdata[45:19]) !== rsp_want.pressure_centimbar) begin
                  failures++;
                  $display("%0t: pressure_centimbar mismatch, expected %0d, got %0d",
                           $time, rsp_want.pressure_centimbar, $signed(rsp_tdata[45:19]));
               end
            end
         end
         if (rx_stall_req && !rx_stall_done) begin
            rx_stall_left = RX_STALL_CYCLES;
            rx_stall_done = 1'b1;
         end
         if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("barometer_second_order_compensation_core_tb NOT OK");
         $finish;
      end
   end

   task automatic write_cal(logic [INDEX_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PRESSURE_SENSITIVITY:   cal_shadow.pressure_sensitivity   = val;
         CSR_PRESSURE_OFFSET:        cal_shadow.pressure_offset        = val;
         CSR_SENSITIVITY_TEMP_COEFF: cal_shadow.sensitivity_temp_coeff = val;
         CSR_OFFSET_TEMP_COEFF:      cal_shadow.offset_temp_coeff      = val;
         CSR_REFERENCE_TEMPERATURE:  cal_shadow.reference_temperature  = val;
         CSR_TEMPERATURE_SLOPE:      cal_shadow.temperature_slope      = val;
         default: ;
      endcase
   endtask

   task automatic load_cal(logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                           logic [15:0] c4, logic [15:0] c5, logic [15:0] c6);
      write_cal(CSR_PRESSURE_SENSITIVITY, c1);
      write_cal(CSR_PRESSURE_OFFSET, c2);
      write_cal(CSR_SENSITIVITY_TEMP_COEFF, c3);
      write_cal(CSR_OFFSET_TEMP_COEFF, c4);
      write_cal(CSR_REFERENCE_TEMPERATURE, c5);
      write_cal(CSR_TEMPERATURE_SLOPE, c6);
   endtask

   // Waits until the sample queue is empty and every issued request has had its response.
   task automatic await_drain();
      while (sample_queue.size() != 0 || items_issued != results_seen)
         @(posedge clock);
   endtask

   task automatic push_pair(logic [23:0] d1, logic [23:0] d2);
      sample_pair_type s;
      s.raw_pressure    = d1;
      s.raw_temperature = d2;
      sample_queue.push_back(s);
   endtask

   // Most raw temperatures sit around the reference point at a random scale,
   // so that the warm, cold and very cold branches all see plenty of traffic.
   task automatic push_random(int unsigned count);
      int unsigned pick, span;
      int          base, offset;
      logic [23:0] d1, d2;
      repeat (count) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)      d1 = 24'h000000;
         else if (pick == 1) d1 = 24'hFFFFFF;
         else                d1 = 24'($urandom());
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            d2 = 24'($urandom());
         end else begin
            span   = $urandom_range(0, 22);
            base   = int'(cal_shadow.reference_temperature) << 8;
            offset = int'($urandom_range(0, 2 * (1 << span))) - (1 << span);
            d2     = 24'(base + offset);
         end
         push_pair(d1, d2);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 24;
      rx_idle_pct = 45;

      // Calibration at its reset value of zero, input extremes.
      push_pair(24'h000000, 24'h000000);
      push_pair(24'hFFFFFF, 24'hFFFFFF);
      push_pair(24'hFFFFFF, 24'h000000);
      push_pair(24'h000000, 24'hFFFFFF);
      await_drain();

      // Typical factory calibration: a warm point, a very cold one, extremes.
      load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      push_pair(24'd9085466, 24'd8569150);
      push_pair(24'd9085466, 24'd7000000);
      push_pair(24'h000000, 24'h000000);
      push_pair(24'hFFFFFF, 24'hFFFFFF);
      await_drain();

      // With C5 = C6 = 32768 the temperature is 2000 + (dT >> 8), which puts
      // both thresholds on exact raw values. Writes to the unused indexes
      // in between must leave the bank untouched.
      write_cal(CSR_REFERENCE_TEMPERATURE, 16'd32768);
      write_cal(CSR_UNUSED_SIX, 16'hFFFF);
      write_cal(CSR_TEMPERATURE_SLOPE, 16'd32768);
      write_cal(CSR_UNUSED_SEVEN, 16'h0000);
      push_pair(24'd9085466, 24'd8388608);
      push_pair(24'd9085466, 24'd8388607);
      push_pair(24'd9085466, 24'd7492608);
      push_pair(24'd9085466, 24'd7492607);
      await_drain();

      // Every calibration word at its maximum.
      load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_pair(24'h000000, 24'h000000);
      push_pair(24'hFFFFFF, 24'hFFFFFF);
      push_pair(24'hFFFFFF, 24'h000000);
      push_pair(24'h000000, 24'hFFFFFF);
      push_pair(24'hFFFFFF, 24'hFFFF00);
      await_drain();

      // Random traffic with a long response hold-off that backs the core up.
      load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
      rx_stall_req = 1'b1;
      push_random(RANDOM_PER_PHASE);
      await_drain();

      tx_idle_pct = 45;
      rx_idle_pct = 24;
      load_cal(16'($urandom()), 16'($urandom()), 16'($urandom()),
               16'($urandom()), 16'($urandom()), 16'($urandom()));
      push_random(RANDOM_PER_PHASE);
      await_drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      load_cal(16'($urandom()), 16'($urandom()), 16'($urandom()),
               16'($urandom()), 16'($urandom()), 16'($urandom_range(32768, 65535)));
      push_random(RANDOM_PER_PHASE);
      await_drain();

      repeat (PIPE_SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("barometer_second_order_compensation_core_tb OK");
      end else begin
         $display("barometer_second_order_compensation_core_tb NOT OK");
      end
      $finish;
   end

endmodule
